[hw/rtl/fmacl_pkg.sv]
package fmacl_pkg;

    localparam int RULES     = 16;
    localparam int RIDX_W    = 4;
    localparam int RCNT_W    = 5;
    localparam int QDEPTH    = 2;

    localparam logic [31:0] ANY_NET = 32'hFFFF_FFFF;

    // flag bits of a rule
    localparam int F_SRCNET  = 0;
    localparam int F_DSTNET  = 1;
    localparam int F_SRCHOST = 2;
    localparam int F_DSTHOST = 3;
    localparam int F_PROTO   = 4;
    localparam int F_PEPCL   = 5;
    localparam int F_SRCSOCK = 6;
    localparam int F_DSTSOCK = 7;
    localparam int F_PERMIT  = 8;

    // configuration register indexes
    localparam logic [1:0] CFG_RULE_COUNT = 2'd0;
    localparam logic [1:0] CFG_EXTENDED   = 2'd1;
    localparam logic [1:0] CFG_PEP_TYPE   = 2'd2;

    localparam logic REQ_WRITE    = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    // rule word selects
    localparam logic [3:0] W_FLAGS   = 4'd0;
    localparam logic [3:0] W_SNET    = 4'd1;
    localparam logic [3:0] W_SNETM   = 4'd2;
    localparam logic [3:0] W_DNET    = 4'd3;
    localparam logic [3:0] W_DNETM   = 4'd4;
    localparam logic [3:0] W_SHOST   = 4'd5;
    localparam logic [3:0] W_SHOSTM  = 4'd6;
    localparam logic [3:0] W_DHOST   = 4'd7;
    localparam logic [3:0] W_DHOSTM  = 4'd8;
    localparam logic [3:0] W_PROTO   = 4'd9;
    localparam logic [3:0] W_CLIENT  = 4'd10;
    localparam logic [3:0] W_SSOCK   = 4'd11;
    localparam logic [3:0] W_DSOCK   = 4'd12;

    typedef struct packed {
        logic        req_type;
        logic [3:0]  rule_index;
        logic [3:0]  word_select;
        logic [47:0] word_data;
        logic [31:0] src_net;
        logic [31:0] dst_net;
        logic [47:0] src_host;
        logic [47:0] dst_host;
        logic [15:0] src_sock;
        logic [15:0] dst_sock;
        logic [7:0]  packet_type;
        logic [15:0] client_type;
    } t_in;

    typedef struct packed {
        logic       permit;
        logic       rule_matched;
        logic [3:0] matched_index;
    } t_out;

    // classify job handed from front to back
    typedef struct packed {
        logic        empty_list;
        logic [RCNT_W-1:0] count;
        logic [31:0] src_net;
        logic [31:0] dst_net;
        logic [47:0] src_host;
        logic [47:0] dst_host;
        logic [15:0] src_sock;
        logic [15:0] dst_sock;
        logic [7:0]  packet_type;
        logic [15:0] client_type;
    } t_job;

    typedef struct packed {
        logic [8:0]  flags;
        logic [31:0] snet;
        logic [31:0] snetm;
        logic [31:0] dnet;
        logic [31:0] dnetm;
        logic [47:0] shost;
        logic [47:0] shostm;
        logic [47:0] dhost;
        logic [47:0] dhostm;
        logic [7:0]  proto;
        logic [15:0] client;
        logic [15:0] ssock;
        logic [15:0] dsock;
    } t_rule;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_TEST,
        S_OUT
    } t_bstate;

endpackage

[hw/rtl/fmacl_front.sv]
module fmacl_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  fmacl_pkg::t_in        i_data,
    input  logic [4:0]            i_rule_count,
    // rule table write port
    output logic                  o_wr_en,
    output logic [3:0]            o_wr_index,
    output logic [3:0]            o_wr_sel,
    output logic [47:0]           o_wr_data,
    // job queue toward the back end
    output fmacl_pkg::t_job       o_job,
    output logic                  o_job_valid,
    input  logic                  i_job_pop
);
    import fmacl_pkg::*;

    t_job         r_q [QDEPTH];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, xfer;
    t_job         job;

    // writes go straight to the table once no classify is queued; classifies queue up
    assign o_ready = (r_cnt != 2'(QDEPTH)) &&
                     ((i_data.req_type == REQ_CLASSIFY) || (r_cnt == '0));
    assign xfer    = i_valid && o_ready;
    assign push    = xfer && (i_data.req_type == REQ_CLASSIFY);
    assign o_wr_en    = xfer && (i_data.req_type == REQ_WRITE);
    assign o_wr_index = i_data.rule_index;
    assign o_wr_sel   = i_data.word_select;
    assign o_wr_data  = i_data.word_data;

    always_comb begin
        job.empty_list  = (i_rule_count == '0);
        job.count       = (i_rule_count > 5'(RULES)) ? 5'(RULES) : i_rule_count;
        job.src_net     = i_data.src_net;
        job.dst_net     = i_data.dst_net;
        job.src_host    = i_data.src_host;
        job.dst_host    = i_data.dst_host;
        job.src_sock    = i_data.src_sock;
        job.dst_sock    = i_data.dst_sock;
        job.packet_type = i_data.packet_type;
        job.client_type = i_data.client_type;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_job_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_job_pop);
        end
    end

    assign o_job       = r_q[r_rp];
    assign o_job_valid = (r_cnt != '0);

endmodule

[hw/rtl/fmacl_back.sv]
module fmacl_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fmacl_pkg::t_job       i_job,
    input  logic                  i_job_valid,
    output logic                  o_job_pop,
    input  logic                  i_extended,
    input  logic [7:0]            i_pep_type,
    input  logic                  i_wr_en,
    input  logic [3:0]            i_wr_index,
    input  logic [3:0]            i_wr_sel,
    input  logic [47:0]           i_wr_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output fmacl_pkg::t_out       o_data
);
    import fmacl_pkg::*;

    // rule table, one memory per word
    logic [8:0]  m_flags  [RULES];
    logic [31:0] m_snet   [RULES];
    logic [31:0] m_snetm  [RULES];
    logic [31:0] m_dnet   [RULES];
    logic [31:0] m_dnetm  [RULES];
    logic [47:0] m_shost  [RULES];
    logic [47:0] m_shostm [RULES];
    logic [47:0] m_dhost  [RULES];
    logic [47:0] m_dhostm [RULES];
    logic [7:0]  m_proto  [RULES];
    logic [15:0] m_client [RULES];
    logic [15:0] m_ssock  [RULES];
    logic [15:0] m_dsock  [RULES];

    t_bstate          r_state, n_state;
    logic [RCNT_W-1:0] r_idx, n_idx;
    t_rule            r_rule;
    t_out             r_out, n_out;
    logic             pass;
    logic             rd_en;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            unique case (i_wr_sel)
                W_FLAGS:  m_flags[i_wr_index]  <= i_wr_data[8:0];
                W_SNET:   m_snet[i_wr_index]   <= i_wr_data[31:0];
                W_SNETM:  m_snetm[i_wr_index]  <= i_wr_data[31:0];
                W_DNET:   m_dnet[i_wr_index]   <= i_wr_data[31:0];
                W_DNETM:  m_dnetm[i_wr_index]  <= i_wr_data[31:0];
                W_SHOST:  m_shost[i_wr_index]  <= i_wr_data;
                W_SHOSTM: m_shostm[i_wr_index] <= i_wr_data;
                W_DHOST:  m_dhost[i_wr_index]  <= i_wr_data;
                W_DHOSTM: m_dhostm[i_wr_index] <= i_wr_data;
                W_PROTO:  m_proto[i_wr_index]  <= i_wr_data[7:0];
                W_CLIENT: m_client[i_wr_index] <= i_wr_data[15:0];
                W_SSOCK:  m_ssock[i_wr_index]  <= i_wr_data[15:0];
                W_DSOCK:  m_dsock[i_wr_index]  <= i_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // registered rule read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rule.flags  <= m_flags[r_idx[RIDX_W-1:0]];
            r_rule.snet   <= m_snet[r_idx[RIDX_W-1:0]];
            r_rule.snetm  <= m_snetm[r_idx[RIDX_W-1:0]];
            r_rule.dnet   <= m_dnet[r_idx[RIDX_W-1:0]];
            r_rule.dnetm  <= m_dnetm[r_idx[RIDX_W-1:0]];
            r_rule.shost  <= m_shost[r_idx[RIDX_W-1:0]];
            r_rule.shostm <= m_shostm[r_idx[RIDX_W-1:0]];
            r_rule.dhost  <= m_dhost[r_idx[RIDX_W-1:0]];
            r_rule.dhostm <= m_dhostm[r_idx[RIDX_W-1:0]];
            r_rule.proto  <= m_proto[r_idx[RIDX_W-1:0]];
            r_rule.client <= m_client[r_idx[RIDX_W-1:0]];
            r_rule.ssock  <= m_ssock[r_idx[RIDX_W-1:0]];
            r_rule.dsock  <= m_dsock[r_idx[RIDX_W-1:0]];
        end
    end

    // rule test against the head job
    always_comb begin
        pass = 1'b1;
        if (r_rule.flags[F_SRCNET] && r_rule.snet != ANY_NET &&
            r_rule.snet != (i_job.src_net & ~r_rule.snetm)) pass = 1'b0;
        if (r_rule.flags[F_DSTNET] && r_rule.dnet != ANY_NET &&
            r_rule.dnet != (i_job.dst_net & ~r_rule.dnetm)) pass = 1'b0;
        if (r_rule.flags[F_SRCHOST] &&
            (i_job.src_host & ~r_rule.shostm) != r_rule.shost) pass = 1'b0;
        if (r_rule.flags[F_DSTHOST] &&
            (i_job.dst_host & ~r_rule.dhostm) != r_rule.dhost) pass = 1'b0;
        if (i_extended) begin
            if (r_rule.flags[F_PROTO]) begin
                if (r_rule.proto != i_job.packet_type) pass = 1'b0;
                if (r_rule.flags[F_PEPCL] && i_job.packet_type == i_pep_type &&
                    r_rule.client != i_job.client_type) pass = 1'b0;
            end
            if (r_rule.flags[F_SRCSOCK] && r_rule.ssock != '0 &&
                r_rule.ssock != i_job.src_sock) pass = 1'b0;
            if (r_rule.flags[F_DSTSOCK] && r_rule.dsock != '0 &&
                r_rule.dsock != i_job.dst_sock) pass = 1'b0;
        end
    end

    // rule walk sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_out     = r_out;
        rd_en     = 1'b0;
        o_job_pop = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_job_valid) begin
                    if (i_job.empty_list) begin
                        n_out     = '{permit: 1'b1, rule_matched: 1'b0, matched_index: '0};
                        o_job_pop = 1'b1;
                        n_state   = S_OUT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                n_state = S_TEST;
            end
            S_TEST: begin
                if (pass) begin
                    n_out = '{permit: r_rule.flags[F_PERMIT], rule_matched: 1'b1,
                              matched_index: r_idx[RIDX_W-1:0]};
                    o_job_pop = 1'b1;
                    n_state   = S_OUT;
                end else if (r_idx + 5'd1 >= i_job.count) begin
                    n_out     = '{permit: 1'b0, rule_matched: 1'b0, matched_index: '0};
                    o_job_pop = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    n_idx   = r_idx + 5'd1;
                    n_state = S_READ;
                end
            end
            S_OUT: begin
                if (i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = (r_state == S_OUT);
    assign o_data  = r_out;

endmodule

[hw/rtl/first_match_access_list_classifier.sv]
// Channel | Direction | Handshake           | Payload
// input   | in        | i_valid / o_ready   | i_data  (fmacl_pkg::t_in)
// result  | out       | o_valid / i_ready   | o_data  (fmacl_pkg::t_out)
// config  | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// Rule writes go straight into the table but wait until no classify is queued. A classify
// walks the table one rule at a time (registered read, then test) from the queue head
// to the result; an empty list gives its result without a walk.
// A two-entry queue lets the front accept classifies while the walk or a
// stalled result holds the back end; a held result blocks the next walk.
// Reset is synchronous, active low; rule words are undefined until written.
module first_match_access_list_classifier (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  fmacl_pkg::t_in   i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output fmacl_pkg::t_out  o_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data
);
    import fmacl_pkg::*;

    logic [4:0]  r_rule_count;
    logic        r_extended;
    logic [7:0]  r_pep_type;
    logic        wr_en;
    logic [3:0]  wr_index, wr_sel;
    logic [47:0] wr_data;
    t_job        job;
    logic        job_valid, job_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_count <= '0;
            r_extended   <= 1'b0;
            r_pep_type   <= 8'd4;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RULE_COUNT: r_rule_count <= i_cfg_data[4:0];
                CFG_EXTENDED:   r_extended   <= i_cfg_data[0];
                CFG_PEP_TYPE:   r_pep_type   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fmacl_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .i_rule_count (r_rule_count),
        .o_wr_en      (wr_en),
        .o_wr_index   (wr_index),
        .o_wr_sel     (wr_sel),
        .o_wr_data    (wr_data),
        .o_job        (job),
        .o_job_valid  (job_valid),
        .i_job_pop    (job_pop)
    );

    fmacl_back u_back (
        .i_clk, .i_rst_n,
        .i_job       (job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .i_extended  (r_extended),
        .i_pep_type  (r_pep_type),
        .i_wr_en     (wr_en),
        .i_wr_index  (wr_index),
        .i_wr_sel    (wr_sel),
        .i_wr_data   (wr_data),
        .o_valid, .i_ready, .o_data
    );

endmodule

[hw/rtl/fmacl_checker.sv]
module fmacl_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             o_valid,
    input  logic             i_ready,
    input  fmacl_pkg::t_out  o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.rule_matched |-> o_data.matched_index == '0)
        else $error("index set without a match");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("back-to-back result without a walk");
endmodule

bind first_match_access_list_classifier fmacl_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_data
);

[dv/first_match_access_list_classifier_checker.sv]
// Watches the packet and result channels, keeps its own copy of the rule
// table and registers, and compares every result with the oldest verdict due.
module first_match_access_list_classifier_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            o_ready,
    input  fmacl_pkg::t_in  i_data,
    input  logic            o_valid,
    input  logic            i_ready,
    input  fmacl_pkg::t_out o_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    output int              o_fail_count,
    output int              o_pending
);
    import fmacl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    t_rule      table_copy [RULES];
    logic [4:0] active_rules;
    logic       extended;
    logic [7:0] pep_type;
    t_out       verdicts [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // store one rule word, trimmed to its width
    function automatic void store_word(t_in it);
        int r;
        r = it.rule_index;
        case (it.word_select)
            W_FLAGS:  table_copy[r].flags  = it.word_data[8:0];
            W_SNET:   table_copy[r].snet   = it.word_data[31:0];
            W_SNETM:  table_copy[r].snetm  = it.word_data[31:0];
            W_DNET:   table_copy[r].dnet   = it.word_data[31:0];
            W_DNETM:  table_copy[r].dnetm  = it.word_data[31:0];
            W_SHOST:  table_copy[r].shost  = it.word_data;
            W_SHOSTM: table_copy[r].shostm = it.word_data;
            W_DHOST:  table_copy[r].dhost  = it.word_data;
            W_DHOSTM: table_copy[r].dhostm = it.word_data;
            W_PROTO:  table_copy[r].proto  = it.word_data[7:0];
            W_CLIENT: table_copy[r].client = it.word_data[15:0];
            W_SSOCK:  table_copy[r].ssock  = it.word_data[15:0];
            W_DSOCK:  table_copy[r].dsock  = it.word_data[15:0];
            default: ;
        endcase
    endfunction

    // does rule r accept the packet
    function automatic bit rule_hit(int r, t_in p);
        t_rule ru;
        ru = table_copy[r];
        if (ru.flags[F_SRCNET] && ru.snet != ANY_NET && ru.snet != (p.src_net & ~ru.snetm))
            return 0;
        if (ru.flags[F_DSTNET] && ru.dnet != ANY_NET && ru.dnet != (p.dst_net & ~ru.dnetm))
            return 0;
        if (ru.flags[F_SRCHOST] && (p.src_host & ~ru.shostm) != ru.shost)
            return 0;
        if (ru.flags[F_DSTHOST] && (p.dst_host & ~ru.dhostm) != ru.dhost)
            return 0;
        if (extended) begin
            if (ru.flags[F_PROTO]) begin
                if (ru.proto != p.packet_type)
                    return 0;
                if (ru.flags[F_PEPCL] && p.packet_type == pep_type
                    && ru.client != p.client_type)
                    return 0;
            end
            if (ru.flags[F_SRCSOCK] && ru.ssock != 0 && ru.ssock != p.src_sock)
                return 0;
            if (ru.flags[F_DSTSOCK] && ru.dsock != 0 && ru.dsock != p.dst_sock)
                return 0;
        end
        return 1;
    endfunction

    // first matching rule decides; empty list permits, no match denies
    function automatic t_out decide(t_in p);
        t_out v;
        int   n;
        n = (active_rules > RULES) ? RULES : active_rules;
        v = '0;
        if (n == 0) begin
            v.permit = 1'b1;
            return v;
        end
        for (int r = 0; r < n; r++) begin
            if (rule_hit(r, p)) begin
                v.permit        = table_copy[r].flags[F_PERMIT];
                v.rule_matched  = 1'b1;
                v.matched_index = r[3:0];
                return v;
            end
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            active_rules = '0;
            extended     = 1'b0;
            pep_type     = 8'd4;
            verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RULE_COUNT: active_rules = i_cfg_data[4:0];
                    CFG_EXTENDED:   extended     = i_cfg_data[0];
                    CFG_PEP_TYPE:   pep_type     = i_cfg_data;
                    default: ;
                endcase
            end
            // result transfer: compare with the oldest verdict
            if (o_valid && i_ready) begin
                if (verdicts.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result permit=%0b matched=%0b idx=%0d",
                                 $realtime, o_data.permit, o_data.rule_matched,
                                 o_data.matched_index);
                end else begin
                    want = verdicts.pop_front();
                    if (o_data.permit !== want.permit
                        || o_data.rule_matched !== want.rule_matched
                        || o_data.matched_index !== want.matched_index) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: result error exp permit=%0b matched=%0b idx=%0d, %s",
                                     $realtime, want.permit, want.rule_matched,
                                     want.matched_index,
                                     $sformatf("got permit=%0b matched=%0b idx=%0d",
                                               o_data.permit, o_data.rule_matched,
                                               o_data.matched_index));
                    end
                end
            end
            // packet transfer: rule write or classify
            if (i_valid && o_ready) begin
                if (i_data.req_type == REQ_WRITE)
                    store_word(i_data);
                else
                    verdicts.push_back(decide(i_data));
            end
        end
        o_pending = verdicts.size();
    end

endmodule

[dv/tb_first_match_access_list_classifier.sv]
module tb_first_match_access_list_classifier;
    import fmacl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 2 * RULES + 8;
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int IN_W         = $bits(t_in);

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in        i_data = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out       o_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_go = 0;
    int cycles = 0;

    // rule words as written, used only to aim packets at rules
    t_rule written [RULES];
    logic [4:0] cur_count;

    first_match_access_list_classifier uut (.*);

    first_match_access_list_classifier_checker chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data, .o_valid, .i_ready,
        .o_data, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("first_match_access_list_classifier: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        int hold_left;
        bit held;
        if (hold_go && !held) begin
            held      = 1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    function automatic logic [47:0] rand_mask48();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return rand48();
            default: return (48'd1 << $urandom_range(47)) - 48'd1;
        endcase
    endfunction

    // offer one item; leaves valid high after the transfer
    task automatic push_item(t_in it);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic push_word(int r, logic [3:0] sel, logic [47:0] d);
        t_in it;
        it = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        it.req_type    = REQ_WRITE;
        it.rule_index  = r[3:0];
        it.word_select = sel;
        it.word_data   = d;
        case (sel)
            W_FLAGS:  written[r].flags  = d[8:0];
            W_SNET:   written[r].snet   = d[31:0];
            W_SNETM:  written[r].snetm  = d[31:0];
            W_DNET:   written[r].dnet   = d[31:0];
            W_DNETM:  written[r].dnetm  = d[31:0];
            W_SHOST:  written[r].shost  = d;
            W_SHOSTM: written[r].shostm = d;
            W_DHOST:  written[r].dhost  = d;
            W_DHOSTM: written[r].dhostm = d;
            W_PROTO:  written[r].proto  = d[7:0];
            W_CLIENT: written[r].client = d[15:0];
            W_SSOCK:  written[r].ssock  = d[15:0];
            W_DSOCK:  written[r].dsock  = d[15:0];
            default: ;
        endcase
        push_item(it);
    endtask

    // a consistent rule: values sit outside their masks, wildcards now and then
    task automatic new_rule(int r);
        logic [47:0] m;
        push_word(r, W_FLAGS, rand48());
        m = rand_mask48();
        push_word(r, W_SNETM, 48'(m[31:0]));
        push_word(r, W_SNET,
                  48'(($urandom_range(7) == 0) ? ANY_NET : ($urandom() & ~m[31:0])));
        m = rand_mask48();
        push_word(r, W_DNETM, 48'(m[31:0]));
        push_word(r, W_DNET,
                  48'(($urandom_range(7) == 0) ? ANY_NET : ($urandom() & ~m[31:0])));
        m = rand_mask48();
        push_word(r, W_SHOSTM, m);
        push_word(r, W_SHOST, rand48() & ~m);
        m = rand_mask48();
        push_word(r, W_DHOSTM, m);
        push_word(r, W_DHOST, rand48() & ~m);
        push_word(r, W_PROTO,
                  48'(($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(7))));
        push_word(r, W_CLIENT, 48'($urandom_range(3)));
        push_word(r, W_SSOCK,
                  48'(($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(65535))));
        push_word(r, W_DSOCK,
                  48'(($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(65535))));
    endtask

    // packet aimed at one of the rules in use, else fully random
    function automatic t_in make_packet(int n);
        t_in   p;
        t_rule ru;
        int    r;
        p = IN_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
        p.req_type = REQ_CLASSIFY;
        if (n > RULES)
            n = RULES;
        if (n > 0 && $urandom_range(99) < 70) begin
            r  = $urandom_range(n - 1);
            ru = written[r];
            if (ru.snet != ANY_NET)
                p.src_net = ru.snet | (p.src_net & ru.snetm);
            if (ru.dnet != ANY_NET)
                p.dst_net = ru.dnet | (p.dst_net & ru.dnetm);
            p.src_host    = ru.shost | (p.src_host & ru.shostm);
            p.dst_host    = ru.dhost | (p.dst_host & ru.dhostm);
            p.packet_type = ru.proto;
            p.client_type = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : ru.client;
            if (ru.ssock != 0)
                p.src_sock = ru.ssock;
            if (ru.dsock != 0)
                p.dst_sock = ru.dsock;
            // near miss on one host bit
            if ($urandom_range(4) == 0)
                p.src_host[$urandom_range(47)] ^= 1'b1;
        end
        return p;
    endfunction

    // drop valid, wait for every result, then let the table walk settle
    task automatic quiesce();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_RULE_COUNT)
            cur_count = val[4:0];
    endtask

    initial begin
        t_in p;
        int  ph_count [8];
        int  ph_ext   [8];
        int  ph_pep   [8];
        int  ph_idle  [8];
        int  ph_stall [8];

        ph_count  = '{16, 1, 31, 0, 5, 16, 9, 16};
        ph_ext    = '{1, 0, 1, 1, 0, 1, 1, 1};
        ph_pep    = '{4, 0, 255, 4, 3, 2, 1, 4};
        ph_idle   = '{0, 65, 0, 27, 0, 65, 0, 27};
        ph_stall  = '{0, 0, 65, 27, 65, 0, 0, 27};
        cur_count = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty list at reset: all-zero and all-one packets
        p = '0;
        p.req_type = REQ_CLASSIFY;
        push_item(p);
        p = '1;
        push_item(p);

        // fill the whole table before any rule is read
        for (int r = 0; r < RULES; r++)
            new_rule(r);
        push_word(3, 4'd13, rand48());
        push_word(7, 4'd14, rand48());
        push_word(11, 4'd15, '1);
        quiesce();
        set_reg(CFG_RULE_COUNT, 8'd16);
        set_reg(CFG_EXTENDED, 8'd1);
        set_reg(CFG_PEP_TYPE, 8'd4);

        // directed classifies against the full table
        push_word(0, W_FLAGS, 48'h1FF);
        push_item(make_packet(1));
        p = '0;
        p.req_type = REQ_CLASSIFY;
        push_item(p);
        p = '1;
        push_item(p);
        for (int k = 0; k < 6; k++)
            push_item(make_packet(RULES));
        quiesce();

        // random phases with different settings and flow patterns
        for (int ph = 0; ph < 8; ph++) begin
            set_reg(CFG_RULE_COUNT, 8'(ph_count[ph]));
            set_reg(CFG_EXTENDED, 8'(ph_ext[ph]));
            set_reg(CFG_PEP_TYPE, 8'(ph_pep[ph]));
            send_idle_pct  = ph_idle[ph];
            recv_stall_pct = ph_stall[ph];
            for (int k = 0; k < 250; k++) begin
                if (ph == 2 && k == 20)
                    hold_go = 1;
                if (ph == 5 && k == 125)
                    quiesce();
                if ($urandom_range(99) < 12) begin
                    if ($urandom_range(9) == 0)
                        new_rule($urandom_range(RULES - 1));
                    else
                        push_word($urandom_range(RULES - 1), 4'($urandom_range(15)),
                                  rand48());
                end else begin
                    push_item(make_packet(cur_count));
                end
            end
            quiesce();
        end

        if (fail_count == 0 && pending == 0)
            $display("first_match_access_list_classifier: match");
        else
            $display("first_match_access_list_classifier: mismatch");
        $finish;
    end

endmodule

[first_match_access_list_classifier.f]
hw/rtl/fmacl_pkg.sv
hw/rtl/fmacl_front.sv
hw/rtl/fmacl_back.sv
hw/rtl/first_match_access_list_classifier.sv
hw/rtl/fmacl_checker.sv
dv/first_match_access_list_classifier_checker.sv
dv/tb_first_match_access_list_classifier.sv
